// File: rtl/brrt_pkg.sv
package brrt_pkg;

  localparam int WINDOW_BLOCKS  = 32;
  localparam int BLOCK_BYTES    = 1024;
  localparam int PENDING_TARGET = 8;

  localparam int BLK_SHIFT  = $clog2(BLOCK_BYTES);
  localparam int IDX_W      = $clog2(WINDOW_BLOCKS);
  localparam int HDR_BYTES  = 6;
  localparam int MAX_PACKET = 2048;
  localparam int COUNT_MAX  = 63;

  localparam logic [7:0] TAG_FIRST  = 8'h51;  // 'Q'
  localparam logic [7:0] TAG_SECOND = 8'h72;  // 'r'

  typedef enum logic [1:0] {
    CMD_DEMAND  = 2'd0,
    CMD_REPLY   = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_NONE        = 3'd0,
    ST_ACCEPTED    = 3'd1,
    ST_BAD_TAG     = 3'd2,
    ST_STALE_ID    = 3'd3,
    ST_INDEX_RANGE = 3'd4,
    ST_DUPLICATE   = 3'd5
  } status_e;

  typedef logic [WINDOW_BLOCKS-1:0] mask_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] room_bytes;
    logic [7:0]  tag_first;
    logic [7:0]  tag_second;
    logic [15:0] reply_id;
    logic [15:0] block_index;
    logic [11:0] packet_length;
  } item_t;

  typedef struct packed {
    logic        send_request;
    logic [15:0] request_id;
    logic [5:0]  request_blocks;
    status_e     reply_status;
    logic [10:0] copy_bytes;
    logic        first_accept;
    logic        unexpected_reply;
    logic [5:0]  outstanding_blocks;
  } result_t;

  typedef struct packed {
    logic [15:0] next_id;
    mask_t       cur_mask;
    mask_t       prev_mask;
    logic [5:0]  count;
    logic        locked;
  } state_t;

endpackage

// File: rtl/brrt_step.sv
module brrt_step
  import brrt_pkg::*;
(
  input  item_t   item_i,
  input  state_t  state_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [24:0] room_up;
  logic [24:0] blocks_need;
  logic [25:0] need_total;
  logic [6:0]  req_n;
  logic [7:0]  count_sum;
  logic [15:0] id_diff;
  logic        sel_cur;
  mask_t       sel_mask;
  logic        seen;
  logic [11:0] len;
  logic [11:0] copy_raw;

  // request sizing: room rounded up to whole blocks plus target minus outstanding, capped at the window
  assign room_up     = {1'b0, item_i.room_bytes} + 25'(BLOCK_BYTES - 1);
  assign blocks_need = room_up >> BLK_SHIFT;
  assign need_total  = {1'b0, blocks_need} + 26'(PENDING_TARGET) - 26'(state_i.count);
  assign req_n       = (need_total > 26'(WINDOW_BLOCKS)) ? 7'(WINDOW_BLOCKS)
                                                         : need_total[6:0];
  assign count_sum   = 8'(state_i.count) + 8'(req_n);

  // reply window: one behind is the current request, two behind the previous
  assign id_diff  = state_i.next_id - item_i.reply_id;
  assign sel_cur  = (id_diff == 16'd1);
  assign sel_mask = sel_cur ? state_i.cur_mask : state_i.prev_mask;
  assign seen     = sel_mask[item_i.block_index[IDX_W-1:0]];

  assign len      = (item_i.packet_length > 12'(MAX_PACKET)) ? 12'(MAX_PACKET)
                                                             : item_i.packet_length;
  assign copy_raw = (len > 12'(HDR_BYTES)) ? len - 12'(HDR_BYTES) : 12'd0;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.reply_status = ST_NONE;

    unique case (cmd_e'(item_i.command))
      CMD_DEMAND: begin
        if (state_i.count < 6'(PENDING_TARGET)) begin
          result_o.send_request   = 1'b1;
          result_o.request_id     = state_i.next_id;
          result_o.request_blocks = 6'(req_n);
          state_o.next_id         = state_i.next_id + 16'd1;
          state_o.prev_mask       = state_i.cur_mask;
          // blocks not asked for are preset so their replies count as duplicates
          if (req_n >= 7'(WINDOW_BLOCKS)) begin
            state_o.cur_mask = '0;
          end else begin
            state_o.cur_mask = {WINDOW_BLOCKS{1'b1}} << req_n;
          end
          state_o.count = (count_sum > 8'(COUNT_MAX)) ? 6'(COUNT_MAX) : count_sum[5:0];
        end
      end
      CMD_REPLY: begin
        priority if (item_i.tag_first != TAG_FIRST || item_i.tag_second != TAG_SECOND) begin
          result_o.reply_status = ST_BAD_TAG;
        end else if (id_diff != 16'd1 && id_diff != 16'd2) begin
          result_o.reply_status = ST_STALE_ID;
        end else if (item_i.block_index >= 16'(WINDOW_BLOCKS)) begin
          result_o.reply_status = ST_INDEX_RANGE;
        end else if (seen) begin
          result_o.reply_status = ST_DUPLICATE;
        end else begin
          result_o.reply_status = ST_ACCEPTED;
          if (sel_cur) begin
            state_o.cur_mask[item_i.block_index[IDX_W-1:0]] = 1'b1;
          end else begin
            state_o.prev_mask[item_i.block_index[IDX_W-1:0]] = 1'b1;
          end
          result_o.first_accept = !state_i.locked;
          state_o.locked        = 1'b1;
          // room below copy_raw is itself below 2048, so 11 bits hold it
          result_o.copy_bytes = (24'(copy_raw) > item_i.room_bytes)
                                ? item_i.room_bytes[10:0] : copy_raw[10:0];
          if (state_i.count == 6'd0) begin
            result_o.unexpected_reply = 1'b1;
          end else begin
            state_o.count = state_i.count - 6'd1;
          end
        end
      end
      CMD_TIMEOUT: begin
        state_o.count = 6'd0;
      end
      default: begin
      end
    endcase

    result_o.outstanding_blocks = state_o.count;
  end

endmodule

// File: rtl/block_request_reply_tracker.sv
// Client-side request/reply tracker. Each input transaction (demand, reply header
// or timeout) yields exactly one result transaction. The block takes one
// transaction per cycle unless the result output stalls; a result is offered
// once its input has passed the input register, then the result register. The
// tracking state (next id, two received-block masks, outstanding count, source
// lock) is updated in the same cycle the result is registered, so back-to-back
// transactions see each other's effects in order. Writing start_id loads the
// next request id; do it only while no transaction is in flight.
module block_request_reply_tracker
  import brrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [23:0] room_bytes_i,
  input  logic [7:0]  tag_first_i,
  input  logic [7:0]  tag_second_i,
  input  logic [15:0] reply_id_i,
  input  logic [15:0] block_index_i,
  input  logic [11:0] packet_length_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_request_o,
  output logic [15:0] request_id_o,
  output logic [5:0]  request_blocks_o,
  output logic [2:0]  reply_status_o,
  output logic [10:0] copy_bytes_o,
  output logic        first_accept_o,
  output logic        unexpected_reply_o,
  output logic [5:0]  outstanding_blocks_o
);

  logic    in_valid_q;
  item_t   in_q;
  item_t   in_d;
  logic    res_valid_q;
  result_t res_q;
  result_t res_d;
  state_t  state_q;
  state_t  state_d;
  logic    advance;

  assign in_d = '{command:       command_i,
                  room_bytes:    room_bytes_i,
                  tag_first:     tag_first_i,
                  tag_second:    tag_second_i,
                  reply_id:      reply_id_i,
                  block_index:   block_index_i,
                  packet_length: packet_length_i};

  assign advance    = !res_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  brrt_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        res_valid_q <= in_valid_q;
      end
      if (cfg_we_i) begin
        state_q.next_id <= cfg_wdata_i;
      end else if (in_valid_q && advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_d;
    end
    if (in_valid_q && advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = res_valid_q;
  assign send_request_o       = res_q.send_request;
  assign request_id_o         = res_q.request_id;
  assign request_blocks_o     = res_q.request_blocks;
  assign reply_status_o       = res_q.reply_status;
  assign copy_bytes_o         = res_q.copy_bytes;
  assign first_accept_o       = res_q.first_accept;
  assign unexpected_reply_o   = res_q.unexpected_reply;
  assign outstanding_blocks_o = res_q.outstanding_blocks;

endmodule

// File: rtl/brrt_checker.sv
module brrt_checker
  import brrt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        send_request_o,
  input logic [15:0] request_id_o,
  input logic [5:0]  request_blocks_o,
  input logic [2:0]  reply_status_o,
  input logic [10:0] copy_bytes_o,
  input logic        first_accept_o,
  input logic        unexpected_reply_o,
  input logic [5:0]  outstanding_blocks_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reply_status_o)
      && $stable(copy_bytes_o) && $stable(request_id_o) && $stable(send_request_o))
    else $error("stalled result changed");

  // a request never carries a reply status and always asks for at least one block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_request_o |->
      reply_status_o == ST_NONE && request_blocks_o != 6'd0)
    else $error("bad request result");

  // only accepted replies copy payload or lock the source
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (copy_bytes_o != 11'd0 || first_accept_o) |->
      reply_status_o == ST_ACCEPTED)
    else $error("copy or first flag on non-accepted reply");

  // unexpected reply only with nothing outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unexpected_reply_o |->
      reply_status_o == ST_ACCEPTED && outstanding_blocks_o == 6'd0)
    else $error("unexpected flag inconsistent");

endmodule

bind block_request_reply_tracker brrt_checker u_brrt_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import brrt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RAND_ITEMS  = 400;
  localparam int SETTLE      = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [23:0] room_bytes_i = '0;
  logic [7:0]  tag_first_i = '0;
  logic [7:0]  tag_second_i = '0;
  logic [15:0] reply_id_i = '0;
  logic [15:0] block_index_i = '0;
  logic [11:0] packet_length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        send_request_o;
  logic [15:0] request_id_o;
  logic [5:0]  request_blocks_o;
  logic [2:0]  reply_status_o;
  logic [10:0] copy_bytes_o;
  logic        first_accept_o;
  logic        unexpected_reply_o;
  logic [5:0]  outstanding_blocks_o;

  // tracker state mirror
  logic [15:0] next_id;
  mask_t       cur_mask, prev_mask;
  logic [5:0]  out_count;
  logic        locked;
  int unsigned cur_span;

  result_t     outcomes_q[$];
  dir_row_t    dir_rows[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          cycles = 0;
  int          send_idle_tab[4] = '{0, 76, 0, 32};
  int          stall_tab[4] = '{0, 0, 76, 32};
  logic [15:0] start_tab[4] = '{16'h0000, 16'h0000, 16'hffff, 16'h8001};

  block_request_reply_tracker i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .room_bytes_i,
    .tag_first_i,
    .tag_second_i,
    .reply_id_i,
    .block_index_i,
    .packet_length_i,
    .out_valid_o,
    .out_ready_i,
    .send_request_o,
    .request_id_o,
    .request_blocks_o,
    .reply_status_o,
    .copy_bytes_o,
    .first_accept_o,
    .unexpected_reply_o,
    .outstanding_blocks_o
  );

  always #5 clk_i = ~clk_i;

  function automatic item_t mk_item(input int unsigned cmd, input int unsigned room,
                                    input int unsigned t1, input int unsigned t2,
                                    input int unsigned rid, input int unsigned bidx,
                                    input int unsigned plen);
    item_t it;
    it.command       = 2'(cmd);
    it.room_bytes    = 24'(room);
    it.tag_first     = 8'(t1);
    it.tag_second    = 8'(t2);
    it.reply_id      = 16'(rid);
    it.block_index   = 16'(bidx);
    it.packet_length = 12'(plen);
    return it;
  endfunction

  function automatic result_t mk_want(input int unsigned send, input int unsigned id,
                                      input int unsigned blocks, input status_e st,
                                      input int unsigned cp, input int unsigned first,
                                      input int unsigned unexp, input int unsigned outb);
    result_t r;
    r.send_request       = 1'(send);
    r.request_id         = 16'(id);
    r.request_blocks     = 6'(blocks);
    r.reply_status       = st;
    r.copy_bytes         = 11'(cp);
    r.first_accept       = 1'(first);
    r.unexpected_reply   = 1'(unexp);
    r.outstanding_blocks = 6'(outb);
    return r;
  endfunction

  // Advances the mirrored state by one transaction and returns its outcome.
  function automatic result_t track_event(input item_t it);
    result_t         r;
    logic [15:0]     diff;
    logic [IDX_W-1:0] idx;
    bit              seen;
    int unsigned     n, len, cp;
    r = '0;
    r.reply_status = ST_NONE;
    case (it.command)
      CMD_DEMAND: begin
        if (32'(out_count) < PENDING_TARGET) begin
          n = (32'(it.room_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES
              + PENDING_TARGET - 32'(out_count);
          if (n > WINDOW_BLOCKS) n = WINDOW_BLOCKS;
          r.send_request   = 1'b1;
          r.request_id     = next_id;
          r.request_blocks = 6'(n);
          next_id   = next_id + 16'd1;
          prev_mask = cur_mask;
          // blocks not asked for are preset so they read as duplicates
          cur_mask  = (n >= WINDOW_BLOCKS) ? '0 : (~mask_t'(0) << n);
          cur_span  = n;
          out_count = (32'(out_count) + n > COUNT_MAX) ? 6'(COUNT_MAX)
                                                      : 6'(32'(out_count) + n);
        end
      end
      CMD_REPLY: begin
        diff = next_id - it.reply_id;
        if (it.tag_first != TAG_FIRST || it.tag_second != TAG_SECOND) begin
          r.reply_status = ST_BAD_TAG;
        end else if (diff != 16'd1 && diff != 16'd2) begin
          r.reply_status = ST_STALE_ID;
        end else if (32'(it.block_index) >= WINDOW_BLOCKS) begin
          r.reply_status = ST_INDEX_RANGE;
        end else begin
          idx  = it.block_index[IDX_W-1:0];
          seen = (diff == 16'd1) ? cur_mask[idx] : prev_mask[idx];
          if (seen) begin
            r.reply_status = ST_DUPLICATE;
          end else begin
            if (diff == 16'd1) cur_mask[idx] = 1'b1;
            else prev_mask[idx] = 1'b1;
            len = (32'(it.packet_length) > MAX_PACKET) ? MAX_PACKET
                                                       : 32'(it.packet_length);
            cp  = (len > HDR_BYTES) ? len - HDR_BYTES : 0;
            if (cp > 32'(it.room_bytes)) cp = 32'(it.room_bytes);
            r.reply_status = ST_ACCEPTED;
            r.copy_bytes   = 11'(cp);
            r.first_accept = ~locked;
            locked = 1'b1;
            if (out_count == 6'd0) r.unexpected_reply = 1'b1;
            else out_count = out_count - 6'd1;
          end
        end
      end
      CMD_TIMEOUT: out_count = '0;
      default: ;
    endcase
    r.outstanding_blocks = out_count;
    return r;
  endfunction

  // Random demands, timeouts, unused commands and replies, the replies mostly well-formed for the live window.
  function automatic item_t random_event();
    item_t       it;
    logic [95:0] noise;
    int unsigned pick, sel;
    noise = {$urandom(), $urandom(), $urandom()};
    it    = noise[$bits(item_t)-1:0];
    pick  = $urandom_range(99);
    if (pick < 30) begin
      it.command = CMD_DEMAND;
      sel = $urandom_range(3);
      case (sel)
        0: it.room_bytes = 24'($urandom_range(4096));
        1: it.room_bytes = 24'($urandom_range(40000));
        2: ;
        default: begin
          case ($urandom_range(4))
            0: it.room_bytes = 24'd0;
            1: it.room_bytes = 24'd1023;
            2: it.room_bytes = 24'd1024;
            3: it.room_bytes = 24'd1025;
            default: it.room_bytes = 24'hffffff;
          endcase
        end
      endcase
    end else if (pick < 80) begin
      it.command    = CMD_REPLY;
      it.tag_first  = TAG_FIRST;
      it.tag_second = TAG_SECOND;
      sel = $urandom_range(99);
      if (sel < 60) begin
        it.reply_id    = next_id - 16'd1;
        it.block_index = 16'($urandom_range(cur_span > 0 ? cur_span - 1 : 0));
      end else if (sel < 80) begin
        it.reply_id    = next_id - 16'd2;
        it.block_index = 16'($urandom_range(WINDOW_BLOCKS - 1));
      end else if (sel < 90) begin
        it.reply_id = next_id - 16'd1;
      end else begin
        it.block_index = 16'($urandom_range(WINDOW_BLOCKS - 1));
      end
      if ($urandom_range(99) < 70) it.packet_length = 12'($urandom_range(MAX_PACKET));
      if ($urandom_range(1) == 0) it.room_bytes = 24'($urandom_range(3000));
    end else if (pick < 88) begin
      it.command = CMD_REPLY;
    end else if (pick < 96) begin
      it.command = CMD_TIMEOUT;
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic flag_error(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_outcome();
    result_t want;
    if (outcomes_q.size() == 0) begin
      flag_error("result transaction with nothing pending");
      return;
    end
    want = outcomes_q.pop_front();
    compare_field("send_request", 32'(send_request_o), 32'(want.send_request));
    compare_field("request_id", 32'(request_id_o), 32'(want.request_id));
    compare_field("request_blocks", 32'(request_blocks_o), 32'(want.request_blocks));
    compare_field("reply_status", 32'(reply_status_o), 32'(want.reply_status));
    compare_field("copy_bytes", 32'(copy_bytes_o), 32'(want.copy_bytes));
    compare_field("first_accept", 32'(first_accept_o), 32'(want.first_accept));
    compare_field("unexpected_reply", 32'(unexpected_reply_o),
                  32'(want.unexpected_reply));
    compare_field("outstanding_blocks", 32'(outstanding_blocks_o),
                  32'(want.outstanding_blocks));
  endtask

  task automatic load_start_id(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    next_id = value;
  endtask

  task automatic drive_event(input item_t it, input bit typed, input result_t want);
    result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= it.command;
    room_bytes_i    <= it.room_bytes;
    tag_first_i     <= it.tag_first;
    tag_second_i    <= it.tag_second;
    reply_id_i      <= it.reply_id;
    block_index_i   <= it.block_index;
    packet_length_i <= it.packet_length;
    do @(posedge clk_i); while (!in_ready_o);
    got = track_event(it);
    outcomes_q.push_back(typed ? want : got);
  endtask

  // valid must already be low; also covers the pipeline latency
  task automatic wait_for_outcomes();
    while (outcomes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_outcome();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    next_id   = '0;
    cur_mask  = '0;
    prev_mask = '0;
    out_count = '0;
    locked    = 1'b0;
    cur_span  = 0;

    // start_id is 16'hffff here, so the first request wraps the id
    dir_rows.push_back('{mk_item(CMD_DEMAND, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_want(1, 16'hffff, 8, ST_NONE, 0, 0, 0, 8)});
    dir_rows.push_back('{mk_item(CMD_DEMAND, 1, 0, 0, 0, 0, 0), 1'b1,
                         mk_want(0, 0, 0, ST_NONE, 0, 0, 0, 8)});
    dir_rows.push_back('{mk_item(CMD_REPLY, 1000, 0, 0, 16'hffff, 0, 100), 1'b1,
                         mk_want(0, 0, 0, ST_BAD_TAG, 0, 0, 0, 8)});
    dir_rows.push_back('{mk_item(CMD_REPLY, 24'hffffff, TAG_FIRST, TAG_SECOND, 16'hffff, 0,
                                 2048), 1'b1,
                         mk_want(0, 0, 0, ST_ACCEPTED, 2042, 1, 0, 7)});
    dir_rows.push_back('{mk_item(CMD_REPLY, 24'hffffff, TAG_FIRST, TAG_SECOND, 16'hffff, 0,
                                 2048), 1'b1,
                         mk_want(0, 0, 0, ST_DUPLICATE, 0, 0, 0, 7)});
    dir_rows.push_back('{mk_item(CMD_REPLY, 1000, TAG_FIRST, TAG_SECOND, 16'hffff, 8, 100),
                         1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_REPLY, 1000, TAG_FIRST, TAG_SECOND, 16'hffff, 32, 100),
                         1'b1, mk_want(0, 0, 0, ST_INDEX_RANGE, 0, 0, 0, 7)});
    dir_rows.push_back('{mk_item(CMD_REPLY, 1000, TAG_FIRST, TAG_SECOND, 16'hffff, 16'hffff,
                                 100), 1'b1,
                         mk_want(0, 0, 0, ST_INDEX_RANGE, 0, 0, 0, 7)});
    dir_rows.push_back('{mk_item(CMD_REPLY, 1000, TAG_FIRST, TAG_SECOND, 0, 1, 100), 1'b1,
                         mk_want(0, 0, 0, ST_STALE_ID, 0, 0, 0, 7)});
    dir_rows.push_back('{mk_item(CMD_REPLY, 1000, TAG_FIRST, TAG_SECOND, 16'hfffe, 1, 5),
                         1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_REPLY, 100, TAG_FIRST, TAG_SECOND, 16'hffff, 2, 4095),
                         1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_REPLY, 5000, TAG_FIRST, TAG_SECOND, 16'hffff, 3, 6),
                         1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_REPLY, 0, TAG_FIRST, TAG_SECOND, 16'hffff, 4, 7),
                         1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_UNUSED, 24'hffffff, 8'hff, 8'hff, 16'hffff, 16'hffff,
                                 12'hfff), 1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_TIMEOUT, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_want(0, 0, 0, ST_NONE, 0, 0, 0, 0)});
    // accepted with nothing outstanding
    dir_rows.push_back('{mk_item(CMD_REPLY, 1000, TAG_FIRST, TAG_SECOND, 16'hffff, 5, 100),
                         1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_DEMAND, 24'hffffff, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_REPLY, 24'hffffff, TAG_FIRST, TAG_SECOND, 0, 31, 1030),
                         1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_REPLY, 1000, TAG_FIRST, 8'h52, 0, 0, 100), 1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_REPLY, 24'hffffff, 8'hff, 8'hff, 16'hffff, 16'hffff,
                                 12'hfff), 1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_TIMEOUT, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_want(0, 0, 0, ST_NONE, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_item(CMD_DEMAND, 1023, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_DEMAND, 1024, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_TIMEOUT, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_item(CMD_DEMAND, 1025, 0, 0, 0, 0, 0), 1'b0, '0});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_start_id(16'hffff);
    foreach (dir_rows[i]) drive_event(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    in_valid_i <= 1'b0;
    wait_for_outcomes();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_idle_tab[p];
      stall_pct     = stall_tab[p];
      load_start_id(p == 1 ? 16'($urandom()) : start_tab[p]);
      for (int k = 0; k < RAND_ITEMS; k++) begin
        // long output stall with the sender still pushing: input backs up
        if (p == 0 && k == 100) hold_asked++;
        if (p == 1 && k == 200) begin
          in_valid_i <= 1'b0;
          wait_for_outcomes();
        end
        drive_event(random_event(), 1'b0, '0);
      end
      in_valid_i <= 1'b0;
      wait_for_outcomes();
    end

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
